// ----- design/erm_pkg.sv -----
// Shared constants, register indexes and controller/datapath interface types
// for the echo range trimmed-mean block. No dependencies.
package erm_pkg;

  // Averaging window and distance scaling
  localparam int WINDOW     = 7;
  localparam int SLOT_W     = $clog2(WINDOW);
  localparam int DIST_W     = 12;
  localparam int DIST_MAX   = 2550;
  localparam int DIST_NUM   = 17;
  localparam int DIST_DEN   = 100;

  // Field and register widths
  localparam int CAP_W      = 16;
  localparam int TOP_W      = 16;
  localparam int OVF_W      = 6;
  localparam int GATE_W     = 13;
  localparam int PERIOD_W   = TOP_W + 1;
  localparam int PROD_W     = OVF_W + PERIOD_W;
  localparam int TICKS_W    = PROD_W + 1;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTER_TOP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GATE        = 2'd2;

  localparam logic [TOP_W-1:0]  TOP_RST     = 16'hFFFF;
  localparam logic [OVF_W-1:0]  TIMEOUT_RST = 6'd2;
  localparam logic [GATE_W-1:0] GATE_RST    = 13'd5000;

  // Tick counts at or above this saturate at DIST_MAX
  localparam int TICKS_SAT  = ((DIST_MAX + 1) * DIST_DEN + DIST_NUM - 1) / DIST_NUM;
  localparam int X_IN_W     = $clog2(TICKS_SAT);
  localparam int X_W        = $clog2(TICKS_SAT * DIST_NUM);

  // Division by DIST_DEN as a reciprocal multiply, exact for x below 2^X_W
  localparam int DIV_SHIFT  = 25;
  localparam int DIV_MUL    = ((1 << DIV_SHIFT) + DIST_DEN - 1) / DIST_DEN;
  localparam int Q_W        = DIV_SHIFT + DIST_W;

  // Trimmed mean: sum of WINDOW samples less max and min, over WINDOW - 2
  localparam int SUM_W      = $clog2(WINDOW * DIST_MAX + 1);
  localparam int TRIM_DIV   = WINDOW - 2;
  localparam int TRIM_W     = $clog2(TRIM_DIV * DIST_MAX + 1);
  localparam int MEAN_SHIFT = TRIM_W + $clog2(TRIM_DIV);
  localparam int MEAN_MUL   = ((1 << MEAN_SHIFT) + TRIM_DIV - 1) / TRIM_DIV;
  localparam int MP_W       = MEAN_SHIFT + DIST_W + 1;

  typedef struct packed {
    logic              ovf_tick;
    logic              rise;
    logic              fall;
    logic              calc_ticks;
    logic              scale;
    logic              divide;
    logic              store;
    logic              walk;
    logic              walk_first;
    logic [SLOT_W-1:0] walk_idx;
    logic              trim;
    logic              mean;
    logic              emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pulse_high;
    logic window_full;
  } dp_status_t;

endpackage

// ----- design/echo_range_trimmed_mean.sv -----
// Top level of the echo range block: joins the sequencer and the datapath.
// Depends on erm_pkg, erm_ctrl and erm_datapath.
//
// Usage: one ultrasonic echo channel. Each input transaction is a timer
// overflow (op_i = 0) or a capture edge (op_i = 1) with its counter value.
// The first capture marks the rise, the next one the fall; overflows seen
// while high extend the pulse or abort it at the timeout count. Each fall
// gives a distance that enters a 7-entry ring; once the ring has been
// filled, each further fall yields one output transaction: the gated
// trimmed mean of the ring in mm.
// Steps: an overflow or a rising capture is handled at acceptance. A fall
// passes through acceptance, tick arithmetic, scaling, reciprocal divide
// and store; when the ring was already full it goes on with a walk over
// the ring, trim, mean and output load, which sets the out_valid_o register.
// in_stall_o is high while a fall is in work. A finished result waits in
// the output register; when the receiver stalls, a following fall is still
// taken and held in its last step until the register is free.
// Reset clears the pulse state, ring fill state and last output, and loads
// the register defaults: counter_top 65535, timeout 2, gate limit 5000.
module echo_range_trimmed_mean (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [erm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [erm_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            op_i,
  input  logic [erm_pkg::CAP_W-1:0]       capture_count_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [erm_pkg::DIST_W-1:0]      distance_mm_o
);

  erm_pkg::ctrl_cmd_t  cmd;
  erm_pkg::dp_status_t status;

  // Sequence each transaction and own both handshakes
  erm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Hold configuration, pulse state, ring and arithmetic
  erm_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .capture_count_i (capture_count_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .distance_mm_o   (distance_mm_o)
  );

endmodule

// ----- design/erm_ctrl.sv -----
// Sequencer for the echo range block: input handshake, measurement steps,
// window walk and output valid. Depends on erm_pkg.
module erm_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   op_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  erm_pkg::dp_status_t    status_i,
  output erm_pkg::ctrl_cmd_t     cmd_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_TICKS = 4'd1;
  localparam logic [3:0] ST_SCALE = 4'd2;
  localparam logic [3:0] ST_DIV   = 4'd3;
  localparam logic [3:0] ST_STORE = 4'd4;
  localparam logic [3:0] ST_WALK  = 4'd5;
  localparam logic [3:0] ST_TRIM  = 4'd6;
  localparam logic [3:0] ST_MEAN  = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  localparam logic [erm_pkg::SLOT_W-1:0] WALK_LAST = erm_pkg::SLOT_W'(erm_pkg::WINDOW - 1);

  logic [3:0]                  state_q, state_d;
  logic [erm_pkg::SLOT_W-1:0]  walk_q, walk_d;
  logic                        out_valid_q, out_valid_d;
  logic                        accept;
  logic                        out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    walk_d  = walk_q;
    cmd_o   = '0;
    cmd_o.walk_idx = walk_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.ovf_tick = !op_i;
          cmd_o.rise     = op_i && !status_i.pulse_high;
          cmd_o.fall     = op_i && status_i.pulse_high;
          if (op_i && status_i.pulse_high) begin
            state_d = ST_TICKS;
          end
        end
      end
      ST_TICKS: begin
        cmd_o.calc_ticks = 1'b1;
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.divide = 1'b1;
        state_d = ST_STORE;
      end
      ST_STORE: begin
        cmd_o.store = 1'b1;
        // results start only once the ring has been filled before this sample
        if (status_i.window_full) begin
          walk_d  = '0;
          state_d = ST_WALK;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_WALK: begin
        cmd_o.walk       = 1'b1;
        cmd_o.walk_first = (walk_q == '0);
        if (walk_q == WALK_LAST) begin
          state_d = ST_TRIM;
        end else begin
          walk_d = walk_q + erm_pkg::SLOT_W'(1);
        end
      end
      ST_TRIM: begin
        cmd_o.trim = 1'b1;
        state_d = ST_MEAN;
      end
      ST_MEAN: begin
        cmd_o.mean = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      walk_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      walk_q      <= walk_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- design/erm_datapath.sv -----
// Datapath for the echo range block: configuration registers, pulse state,
// tick arithmetic, distance scaling, sample ring and trimmed mean. Depends on erm_pkg.
module erm_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [erm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [erm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [erm_pkg::CAP_W-1:0]          capture_count_i,
  input  erm_pkg::ctrl_cmd_t                 cmd_i,
  output erm_pkg::dp_status_t                status_o,
  output logic [erm_pkg::DIST_W-1:0]         distance_mm_o
);

  localparam logic [erm_pkg::SLOT_W-1:0] SLOT_LAST = erm_pkg::SLOT_W'(erm_pkg::WINDOW - 1);

  // Configuration
  logic [erm_pkg::TOP_W-1:0]   top_q;
  logic [erm_pkg::OVF_W-1:0]   timeout_q;
  logic [erm_pkg::GATE_W-1:0]  gate_q;

  // Control state
  logic                        pulse_q;
  logic [erm_pkg::OVF_W-1:0]   ovf_q;
  logic [erm_pkg::CAP_W-1:0]   rise_q;
  logic [erm_pkg::SLOT_W-1:0]  slot_q;
  logic                        full_q;
  logic [erm_pkg::DIST_W-1:0]  last_q;

  // Payload
  logic [erm_pkg::CAP_W-1:0]          cap_q;
  logic [erm_pkg::PROD_W-1:0]         prod_q, prod_d;
  logic signed [erm_pkg::TICKS_W-1:0] ticks_q, ticks_d;
  logic                               neg_q, sat_q;
  logic [erm_pkg::X_W-1:0]            x_q, x_d;
  logic [erm_pkg::Q_W-1:0]            q_q, q_d;
  logic [erm_pkg::DIST_W-1:0]         dist_mm;
  logic [erm_pkg::DIST_W-1:0]         hist_q [erm_pkg::WINDOW];
  logic [erm_pkg::DIST_W-1:0]         walk_val;
  logic [erm_pkg::SUM_W-1:0]          sum_q;
  logic [erm_pkg::DIST_W-1:0]         max_q, min_q;
  logic [erm_pkg::TRIM_W-1:0]         trim_q, trim_d;
  logic [erm_pkg::MP_W-1:0]           mp_q, mp_d;
  logic [erm_pkg::DIST_W-1:0]         mean;
  logic                               gate_pass;
  logic [erm_pkg::DIST_W-1:0]         out_q;
  logic [erm_pkg::PERIOD_W-1:0]       period;

  assign status_o.pulse_high  = pulse_q;
  assign status_o.window_full = full_q;
  assign distance_mm_o        = out_q;

  assign period  = erm_pkg::PERIOD_W'(top_q) + erm_pkg::PERIOD_W'(1);
  assign prod_d  = erm_pkg::PROD_W'(ovf_q) * erm_pkg::PROD_W'(period);
  assign ticks_d = $signed(erm_pkg::TICKS_W'(cap_q) - erm_pkg::TICKS_W'(rise_q)
                           + erm_pkg::TICKS_W'(prod_q));
  assign x_d     = erm_pkg::X_W'(ticks_q[erm_pkg::X_IN_W-1:0]) * erm_pkg::X_W'(erm_pkg::DIST_NUM);
  assign q_d     = erm_pkg::Q_W'(x_q) * erm_pkg::Q_W'(erm_pkg::DIV_MUL);

  always_comb begin
    priority if (neg_q) begin
      dist_mm = '0;
    end else if (sat_q) begin
      dist_mm = erm_pkg::DIST_W'(erm_pkg::DIST_MAX);
    end else begin
      dist_mm = q_q[erm_pkg::DIV_SHIFT +: erm_pkg::DIST_W];
    end
  end

  assign walk_val  = hist_q[cmd_i.walk_idx];
  assign trim_d    = erm_pkg::TRIM_W'(sum_q - erm_pkg::SUM_W'(max_q) - erm_pkg::SUM_W'(min_q));
  assign mp_d      = erm_pkg::MP_W'(trim_q) * erm_pkg::MP_W'(erm_pkg::MEAN_MUL);
  assign mean      = mp_q[erm_pkg::MEAN_SHIFT +: erm_pkg::DIST_W];
  assign gate_pass = {1'b0, mean} < gate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q     <= erm_pkg::TOP_RST;
      timeout_q <= erm_pkg::TIMEOUT_RST;
      gate_q    <= erm_pkg::GATE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        erm_pkg::CFG_COUNTER_TOP: top_q     <= cfg_data_i[erm_pkg::TOP_W-1:0];
        erm_pkg::CFG_TIMEOUT:     timeout_q <= cfg_data_i[erm_pkg::OVF_W-1:0];
        erm_pkg::CFG_GATE:        gate_q    <= cfg_data_i[erm_pkg::GATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_q <= 1'b0;
      ovf_q   <= '0;
      rise_q  <= '0;
      slot_q  <= '0;
      full_q  <= 1'b0;
      last_q  <= '0;
    end else begin
      if (cmd_i.ovf_tick && pulse_q) begin
        // abort silently on timeout
        if (ovf_q >= timeout_q) begin
          pulse_q <= 1'b0;
          ovf_q   <= '0;
        end else begin
          ovf_q <= ovf_q + erm_pkg::OVF_W'(1);
        end
      end
      if (cmd_i.rise) begin
        rise_q  <= capture_count_i;
        pulse_q <= 1'b1;
        ovf_q   <= '0;
      end
      if (cmd_i.fall) begin
        pulse_q <= 1'b0;
        ovf_q   <= '0;
      end
      if (cmd_i.store) begin
        if (slot_q == SLOT_LAST) begin
          slot_q <= '0;
          full_q <= 1'b1;
        end else begin
          slot_q <= slot_q + erm_pkg::SLOT_W'(1);
        end
      end
      if (cmd_i.emit && gate_pass) begin
        last_q <= mean;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fall) begin
      cap_q  <= capture_count_i;
      prod_q <= prod_d;
    end
    if (cmd_i.calc_ticks) begin
      ticks_q <= ticks_d;
    end
    if (cmd_i.scale) begin
      neg_q <= ticks_q[erm_pkg::TICKS_W-1] || (ticks_q == '0);
      sat_q <= ticks_q >= $signed(erm_pkg::TICKS_W'(erm_pkg::TICKS_SAT));
      x_q   <= x_d;
    end
    if (cmd_i.divide) begin
      q_q <= q_d;
    end
    if (cmd_i.store) begin
      hist_q[slot_q] <= dist_mm;
    end
    if (cmd_i.walk) begin
      if (cmd_i.walk_first) begin
        sum_q <= erm_pkg::SUM_W'(walk_val);
        max_q <= walk_val;
        min_q <= walk_val;
      end else begin
        sum_q <= sum_q + erm_pkg::SUM_W'(walk_val);
        if (walk_val > max_q) max_q <= walk_val;
        if (walk_val < min_q) min_q <= walk_val;
      end
    end
    if (cmd_i.trim) begin
      trim_q <= trim_d;
    end
    if (cmd_i.mean) begin
      mp_q <= mp_d;
    end
    if (cmd_i.emit) begin
      out_q <= gate_pass ? mean : last_q;
    end
  end

endmodule
